// ----- hw/rtl/belct_pkg.sv -----
// Package: shared constants and types for the event log and counter table.
package belct_pkg;

    localparam int LOG_DEPTH_D      = 32;
    localparam int COUNTER_DEPTH_D  = 16;
    localparam int EVENT_ID_DEPTH_D = 16;
    localparam int ID_BITS_D        = 32;

    localparam logic [2:0] CMD_REG_EVENT   = 3'd0;
    localparam logic [2:0] CMD_REG_COUNTER = 3'd1;
    localparam logic [2:0] CMD_LOG_EVENT   = 3'd2;
    localparam logic [2:0] CMD_ADD_COUNTER = 3'd3;
    localparam logic [2:0] CMD_HALT        = 3'd4;
    localparam logic [2:0] CMD_SNAPSHOT    = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STOPPED     = 3'd1;
    localparam logic [2:0] ST_UNK_EVENT   = 3'd2;
    localparam logic [2:0] ST_UNK_COUNTER = 3'd3;
    localparam logic [2:0] ST_CAPACITY    = 3'd4;
    localparam logic [2:0] ST_DROPPED     = 3'd5;
    localparam logic [2:0] ST_OVERFLOW    = 3'd6;
    localparam logic [2:0] ST_INVALID     = 3'd7;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_COUNTER = 2'd2;

    localparam logic [2:0] REG_LOG_LIMIT  = 3'd0;
    localparam logic [2:0] REG_CNT_LIMIT  = 3'd1;
    localparam logic [2:0] REG_EVID_LIMIT = 3'd2;
    localparam logic [2:0] REG_CNID_LIMIT = 3'd3;
    localparam logic [2:0] REG_FILTER     = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic       exec;       // evaluate and commit the held command
        logic       snap_start; // emit header, count the query
        logic       emit_event; // emit log entry at read pointer
        logic       emit_cntr;  // emit counter at read pointer
        logic       ptr_clear;
        logic       ptr_inc;
        logic       rd_issue;   // register memory read at pointer
    } belct_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       ev_last;    // pointer at last log entry
        logic       cn_last;    // pointer at last counter
        logic       ev_none;
        logic       cn_none;
    } belct_stat_t;

endpackage

// ----- hw/rtl/bounded_event_log_and_counter_table_top.sv -----
// Top level: bounded event log and counter table.
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: command[2:0], item_id[34:3], amount[98:35]
//  m_axis   | out       | tdata records, tuser kind, tlast final record
//  cfg      | in        | cfg_we, cfg_addr, cfg_wdata
//
// Commands run in two steps: accept, then execute into the output register;
// execution waits while that register still holds an untaken record. A snapshot
// loads its header first, then each event and counter record in turn, each read
// into a register from memory first. Reset clears counts and flags and
// sets every limit to its maximum; table contents are undefined until written.
// A stalled m_axis holds the record in place and the sequencer waits.
module bounded_event_log_and_counter_table_top
#(
    parameter int LOG_DEPTH      = belct_pkg::LOG_DEPTH_D,
    parameter int COUNTER_DEPTH  = belct_pkg::COUNTER_DEPTH_D,
    parameter int EVENT_ID_DEPTH = belct_pkg::EVENT_ID_DEPTH_D,
    parameter int ID_BITS        = belct_pkg::ID_BITS_D
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // command, item_id, amount
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], record_id[34:3], record_value[98:35], record_updates[162:99],
    // events_held[168:163], counters_held[173:169], drops[205:174], halted_flag[206]
    output logic [207:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [5:0]   cfg_wdata
);

    belct_pkg::belct_cmd_t  cmd;
    belct_pkg::belct_stat_t stat;
    logic busy, is_snap, in_fire, out_free;

    logic [2:0]  st;
    logic [31:0] rid, drops;
    logic [63:0] rval, rupd;
    logic [5:0]  evh;
    logic [4:0]  cnh;
    logic        hlt;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    belct_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .is_snap(is_snap),
        .out_free(out_free), .stat(stat), .busy(busy), .cmd(cmd)
    );

    belct_dp
    #(
        .LOG_DEPTH(LOG_DEPTH), .COUNTER_DEPTH(COUNTER_DEPTH),
        .EVENT_ID_DEPTH(EVENT_ID_DEPTH), .ID_BITS(ID_BITS)
    )
    u_dp
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .in_command(s_axis_tdata[2:0]), .in_item_id(s_axis_tdata[34:3]),
        .in_amount(s_axis_tdata[98:35]),
        .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
        .cmd(cmd), .stat(stat), .is_snap(is_snap),
        .out_take(m_axis_tready), .out_valid(m_axis_tvalid),
        .o_status(st), .o_kind(m_axis_tuser), .o_record_id(rid),
        .o_record_value(rval), .o_record_updates(rupd),
        .o_events_held(evh), .o_counters_held(cnh), .o_drops(drops),
        .o_halted(hlt), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, hlt, drops, cnh, evh, rupd, rval, rid, st};

endmodule

// ----- hw/rtl/belct_ctrl.sv -----
// Controller: sequences command execution and snapshot streaming.
module belct_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  is_snap,
    input  logic                  out_free,
    input  belct_pkg::belct_stat_t stat,
    output logic                  busy,
    output belct_pkg::belct_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_EV_RD, S_EV_OUT, S_CN_RD, S_CN_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.ptr_clear = 1'b1;
                    if (!is_snap)
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.snap_start = 1'b1;
                        if (!stat.ev_none)
                        begin
                            state_next = S_EV_RD;
                        end
                        else if (!stat.cn_none)
                        begin
                            state_next = S_CN_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_EV_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EV_OUT;
            end
            S_EV_OUT:
            begin
                if (out_free)
                begin
                    cmd.emit_event = 1'b1;
                    if (!stat.ev_last)
                    begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = S_EV_RD;
                    end
                    else
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = stat.cn_none ? S_IDLE : S_CN_RD;
                    end
                end
            end
            S_CN_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_CN_OUT;
            end
            S_CN_OUT:
            begin
                if (out_free)
                begin
                    cmd.emit_cntr = 1'b1;
                    if (!stat.cn_last)
                    begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = S_CN_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/belct_dp.sv -----
// Datapath: id tables, log and counter memories, totals and output register.
module belct_dp
#(
    parameter int LOG_DEPTH      = belct_pkg::LOG_DEPTH_D,
    parameter int COUNTER_DEPTH  = belct_pkg::COUNTER_DEPTH_D,
    parameter int EVENT_ID_DEPTH = belct_pkg::EVENT_ID_DEPTH_D,
    parameter int ID_BITS        = belct_pkg::ID_BITS_D
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [2:0]             in_command,
    input  logic [31:0]            in_item_id,
    input  logic [63:0]            in_amount,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_idx,
    input  logic [5:0]             cfg_data,
    input  belct_pkg::belct_cmd_t  cmd,
    output belct_pkg::belct_stat_t stat,
    output logic                   is_snap,
    input  logic                   out_take,
    output logic                   out_valid,
    output logic [2:0]             o_status,
    output logic [1:0]             o_kind,
    output logic [31:0]            o_record_id,
    output logic [63:0]            o_record_value,
    output logic [63:0]            o_record_updates,
    output logic [5:0]             o_events_held,
    output logic [4:0]             o_counters_held,
    output logic [31:0]            o_drops,
    output logic                   o_halted,
    output logic                   o_last
);

    localparam int LW = $clog2(LOG_DEPTH + 1);
    localparam int CW = $clog2(COUNTER_DEPTH + 1);
    localparam int EW = $clog2(EVENT_ID_DEPTH + 1);
    localparam int LA = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CA = (COUNTER_DEPTH > 1) ? $clog2(COUNTER_DEPTH) : 1;
    localparam int EA = (EVENT_ID_DEPTH > 1) ? $clog2(EVENT_ID_DEPTH) : 1;
    localparam int PW = (LA > CA) ? LA : CA;
    localparam logic [63:0] ALL64 = '1;

    // configuration
    logic [5:0] log_lim_reg;
    logic [4:0] cnt_lim_reg, evid_lim_reg, cnid_lim_reg;
    logic       filter_reg;

    // held command
    logic [2:0]         cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [63:0]        amt_reg;

    logic [ID_BITS-1:0] ev_ids  [EVENT_ID_DEPTH];
    logic [ID_BITS-1:0] cn_ids  [COUNTER_DEPTH];
    logic [63:0]        cn_val  [COUNTER_DEPTH];
    logic [63:0]        cn_upd  [COUNTER_DEPTH];
    logic [ID_BITS-1:0] log_id  [LOG_DEPTH];
    logic [63:0]        log_pay [LOG_DEPTH];

    logic [EW-1:0] ev_used_reg;
    logic [CW-1:0] cn_used_reg;
    logic [LW-1:0] log_used_reg;
    logic [31:0]   drop_reg;
    logic [63:0]   upd_tot_reg, qry_tot_reg;
    logic          halted_reg;
    logic [2:0]    last_st_reg;
    logic [PW-1:0] ptr_reg;

    logic [ID_BITS-1:0] rd_lid_reg, rd_cid_reg;
    logic [63:0]        rd_lpay_reg, rd_cval_reg, rd_cupd_reg;

    logic          cfg_ok;
    logic          ev_hit, cn_hit;
    logic [CA-1:0] cn_slot;
    logic [2:0]    st_new;
    logic [63:0]   sel_val, sel_upd;

    assign cfg_ok = (log_lim_reg != 6'd0) && ({26'd0, log_lim_reg} <= 32'(LOG_DEPTH))
                 && (cnt_lim_reg != 5'd0) && ({27'd0, cnt_lim_reg} <= 32'(COUNTER_DEPTH))
                 && (evid_lim_reg != 5'd0) && ({27'd0, evid_lim_reg} <= 32'(EVENT_ID_DEPTH))
                 && (cnid_lim_reg != 5'd0) && ({27'd0, cnid_lim_reg} <= 32'(COUNTER_DEPTH));

    assign is_snap = (cmd_reg == belct_pkg::CMD_SNAPSHOT);

    // parallel match over the small id tables
    always_comb
    begin
        ev_hit  = 1'b0;
        cn_hit  = 1'b0;
        cn_slot = '0;
        for (int i = 0; i < EVENT_ID_DEPTH; i++)
        begin
            if ((i < 32'(ev_used_reg)) && (ev_ids[i] == id_reg))
            begin
                ev_hit = 1'b1;
            end
        end
        for (int i = COUNTER_DEPTH - 1; i >= 0; i--)
        begin
            if ((i < 32'(cn_used_reg)) && (cn_ids[i] == id_reg))
            begin
                cn_hit  = 1'b1;
                cn_slot = CA'(i);
            end
        end
    end

    assign sel_val = cn_val[cn_slot];
    assign sel_upd = cn_upd[cn_slot];

    always_comb
    begin
        st_new = belct_pkg::ST_OK;
        if (!cfg_ok)
        begin
            st_new = belct_pkg::ST_INVALID;
        end
        else if (cmd_reg == belct_pkg::CMD_HALT)
        begin
            st_new = belct_pkg::ST_OK;
        end
        else if (halted_reg)
        begin
            st_new = belct_pkg::ST_STOPPED;
        end
        else
        begin
            case (cmd_reg)
                belct_pkg::CMD_REG_EVENT:
                begin
                    if (id_reg == '0)
                        st_new = belct_pkg::ST_UNK_EVENT;
                    else if (ev_hit)
                        st_new = belct_pkg::ST_OK;
                    else if ({{(32-EW){1'b0}}, ev_used_reg} >= {27'd0, evid_lim_reg})
                        st_new = belct_pkg::ST_CAPACITY;
                end
                belct_pkg::CMD_REG_COUNTER:
                begin
                    if (id_reg == '0)
                        st_new = belct_pkg::ST_UNK_COUNTER;
                    else if (cn_hit)
                        st_new = belct_pkg::ST_OK;
                    else if (({{(32-CW){1'b0}}, cn_used_reg} >= {27'd0, cnid_lim_reg})
                          || ({{(32-CW){1'b0}}, cn_used_reg} >= {27'd0, cnt_lim_reg}))
                        st_new = belct_pkg::ST_CAPACITY;
                end
                belct_pkg::CMD_LOG_EVENT:
                begin
                    if (filter_reg && !ev_hit)
                        st_new = belct_pkg::ST_UNK_EVENT;
                    else if ({{(32-LW){1'b0}}, log_used_reg} >= {26'd0, log_lim_reg})
                        st_new = belct_pkg::ST_DROPPED;
                end
                belct_pkg::CMD_ADD_COUNTER:
                begin
                    if (!cn_hit)
                        st_new = belct_pkg::ST_UNK_COUNTER;
                    else if (sel_val > (ALL64 - amt_reg))
                        st_new = belct_pkg::ST_OVERFLOW;
                end
                default:
                begin
                    st_new = belct_pkg::ST_OK;
                end
            endcase
        end
    end

    assign stat.ev_none = (log_used_reg == '0);
    assign stat.cn_none = (cn_used_reg == '0);
    assign stat.ev_last = ({{(32-PW){1'b0}}, ptr_reg} + 32'd1 == {{(32-LW){1'b0}}, log_used_reg});
    assign stat.cn_last = ({{(32-PW){1'b0}}, ptr_reg} + 32'd1 == {{(32-CW){1'b0}}, cn_used_reg});

    logic run_cmd;
    assign run_cmd = cmd.exec && (cmd_reg <= belct_pkg::CMD_HALT);

    // memories and tables
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_command;
            id_reg  <= ID_BITS'(in_item_id);
            amt_reg <= in_amount;
        end
        if (run_cmd && (st_new == belct_pkg::ST_OK))
        begin
            case (cmd_reg)
                belct_pkg::CMD_REG_EVENT:
                begin
                    if (!ev_hit)
                        ev_ids[ev_used_reg[EA-1:0]] <= id_reg;
                end
                belct_pkg::CMD_REG_COUNTER:
                begin
                    if (!cn_hit)
                    begin
                        cn_ids[cn_used_reg[CA-1:0]] <= id_reg;
                        cn_val[cn_used_reg[CA-1:0]] <= '0;
                        cn_upd[cn_used_reg[CA-1:0]] <= '0;
                    end
                end
                belct_pkg::CMD_LOG_EVENT:
                begin
                    log_id[log_used_reg[LA-1:0]]  <= id_reg;
                    log_pay[log_used_reg[LA-1:0]] <= amt_reg;
                end
                belct_pkg::CMD_ADD_COUNTER:
                begin
                    cn_val[cn_slot] <= sel_val + amt_reg;
                    cn_upd[cn_slot] <= (sel_upd == ALL64) ? sel_upd : sel_upd + 64'd1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.rd_issue)
        begin
            rd_lid_reg  <= log_id[ptr_reg[LA-1:0]];
            rd_lpay_reg <= log_pay[ptr_reg[LA-1:0]];
            rd_cid_reg  <= cn_ids[ptr_reg[CA-1:0]];
            rd_cval_reg <= cn_val[ptr_reg[CA-1:0]];
            rd_cupd_reg <= cn_upd[ptr_reg[CA-1:0]];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            o_status         <= (cmd_reg <= belct_pkg::CMD_HALT) ? st_new : last_st_reg;
            o_kind           <= belct_pkg::KIND_HEADER;
            o_record_id      <= '0;
            o_record_value   <= '0;
            o_record_updates <= '0;
            o_last           <= 1'b1;
        end
        else if (cmd.snap_start)
        begin
            o_status         <= last_st_reg;
            o_kind           <= belct_pkg::KIND_HEADER;
            o_record_id      <= '0;
            o_record_value   <= upd_tot_reg;
            o_record_updates <= (!halted_reg && qry_tot_reg != ALL64)
                                ? qry_tot_reg + 64'd1 : qry_tot_reg;
            o_last           <= stat.ev_none && stat.cn_none;
        end
        else if (cmd.emit_event)
        begin
            o_status         <= last_st_reg;
            o_kind           <= belct_pkg::KIND_EVENT;
            o_record_id      <= 32'(rd_lid_reg);
            o_record_value   <= rd_lpay_reg;
            o_record_updates <= '0;
            o_last           <= stat.ev_last && stat.cn_none;
        end
        else if (cmd.emit_cntr)
        begin
            o_status         <= last_st_reg;
            o_kind           <= belct_pkg::KIND_COUNTER;
            o_record_id      <= 32'(rd_cid_reg);
            o_record_value   <= rd_cval_reg;
            o_record_updates <= rd_cupd_reg;
            o_last           <= stat.cn_last;
        end
        if (cmd.exec || cmd.snap_start || cmd.emit_event || cmd.emit_cntr)
        begin
            o_events_held   <= 6'(log_used_reg + ((run_cmd && st_new == belct_pkg::ST_OK
                               && cmd_reg == belct_pkg::CMD_LOG_EVENT) ? LW'(1) : LW'(0)));
            o_counters_held <= 5'(cn_used_reg + ((run_cmd && st_new == belct_pkg::ST_OK
                               && cmd_reg == belct_pkg::CMD_REG_COUNTER && !cn_hit)
                               ? CW'(1) : CW'(0)));
            o_drops         <= (run_cmd && st_new == belct_pkg::ST_DROPPED
                                && drop_reg != 32'hFFFF_FFFF) ? drop_reg + 32'd1 : drop_reg;
            o_halted        <= halted_reg || (run_cmd && cmd_reg == belct_pkg::CMD_HALT && cfg_ok);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_lim_reg  <= 6'd32;
            cnt_lim_reg  <= 5'd16;
            evid_lim_reg <= 5'd16;
            cnid_lim_reg <= 5'd16;
            filter_reg   <= 1'b0;
            ev_used_reg  <= '0;
            cn_used_reg  <= '0;
            log_used_reg <= '0;
            drop_reg     <= '0;
            upd_tot_reg  <= '0;
            qry_tot_reg  <= '0;
            halted_reg   <= 1'b0;
            last_st_reg  <= (LOG_DEPTH >= 32 && COUNTER_DEPTH >= 16 && EVENT_ID_DEPTH >= 16)
                            ? belct_pkg::ST_OK : belct_pkg::ST_INVALID;
            ptr_reg      <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    belct_pkg::REG_LOG_LIMIT:  log_lim_reg  <= cfg_data;
                    belct_pkg::REG_CNT_LIMIT:  cnt_lim_reg  <= cfg_data[4:0];
                    belct_pkg::REG_EVID_LIMIT: evid_lim_reg <= cfg_data[4:0];
                    belct_pkg::REG_CNID_LIMIT: cnid_lim_reg <= cfg_data[4:0];
                    belct_pkg::REG_FILTER:     filter_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (run_cmd)
            begin
                last_st_reg <= st_new;
                if (cmd_reg == belct_pkg::CMD_HALT && cfg_ok)
                    halted_reg <= 1'b1;
                if (st_new == belct_pkg::ST_DROPPED && drop_reg != 32'hFFFF_FFFF)
                    drop_reg <= drop_reg + 32'd1;
                if (st_new == belct_pkg::ST_OK)
                begin
                    case (cmd_reg)
                        belct_pkg::CMD_REG_EVENT:
                            if (!ev_hit) ev_used_reg <= ev_used_reg + EW'(1);
                        belct_pkg::CMD_REG_COUNTER:
                            if (!cn_hit) cn_used_reg <= cn_used_reg + CW'(1);
                        belct_pkg::CMD_LOG_EVENT:
                            log_used_reg <= log_used_reg + LW'(1);
                        belct_pkg::CMD_ADD_COUNTER:
                            if (upd_tot_reg != ALL64) upd_tot_reg <= upd_tot_reg + 64'd1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (cmd.snap_start && !halted_reg && qry_tot_reg != ALL64)
                qry_tot_reg <= qry_tot_reg + 64'd1;
            if (cmd.ptr_clear)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + PW'(1);
            if (cmd.exec || cmd.snap_start || cmd.emit_event || cmd.emit_cntr)
                out_valid <= 1'b1;
            else if (out_take)
                out_valid <= 1'b0;
        end
    end

endmodule
